@@ rtl/fqrm_pkg.sv @@
`timescale 1ns / 1ps

package fqrm_pkg;

  localparam int unsigned PID_W = 22;
  localparam int unsigned COUNT_FW = 5;

  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_POP = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  localparam logic [1:0] STS_OK = 2'd0;
  localparam logic [1:0] STS_EMPTY = 2'd1;
  localparam logic [1:0] STS_NOT_FOUND = 2'd2;
  localparam logic [1:0] STS_FULL = 2'd3;

  typedef struct packed {
    logic [1:0]       action;
    logic [PID_W-1:0] pid;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [PID_W-1:0]    out_pid;
    logic [COUNT_FW-1:0] count;
  } rsp_t;

  typedef struct packed {
    logic load_req;
    logic match;
    logic apply;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

@@ rtl/fqrm_ctrl.sv @@
`timescale 1ns / 1ps

module fqrm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  fqrm_pkg::sts_t  sts_i,
  output fqrm_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_MATCH  = 3'b010,
    S_UPDATE = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd_o.match = 1'b1;
        state_d = S_UPDATE;
      end
      S_UPDATE: begin
        if (sts_i.out_free) begin
          cmd_o.apply = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_one_hot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("Controller state is not one-hot.");

  a_accept_to_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_req |=> cmd_o.match) else $error("Accepted request did not go to match.");

  a_apply_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.apply |=> !in_stall_o) else $error("Controller did not return to idle.");

endmodule

@@ rtl/fqrm_datapath.sv @@
`timescale 1ns / 1ps

module fqrm_datapath #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ID_BITS = 22
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fqrm_pkg::req_t  in_req_i,
  input  fqrm_pkg::cmd_t  cmd_i,
  output fqrm_pkg::sts_t  sts_o,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output fqrm_pkg::rsp_t  out_rsp_o
);

  localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

  logic [ID_BITS-1:0] in_pid;
  logic [1:0]         act_q;
  logic [ID_BITS-1:0] pid_q;
  logic [ID_BITS-1:0] entries_q [DEPTH];
  logic [DEPTH-1:0]   match_q, match_d;
  logic [DEPTH-1:0]   shift_en;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               out_valid_q;
  fqrm_pkg::rsp_t     rsp_q, rsp_d;
  logic [ID_BITS-1:0] rid;
  logic               do_push, do_shift, full, empty, hit;

  for (genvar b = 0; b < ID_BITS; b++) begin : g_in_pid
    if (b < fqrm_pkg::PID_W) begin : g_bit
      assign in_pid[b] = in_req_i.pid[b];
    end else begin : g_zero
      assign in_pid[b] = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      act_q <= in_req_i.action;
      pid_q <= in_pid;
    end
    if (cmd_i.match) begin
      match_q <= match_d;
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_d[i] = (entries_q[i] == pid_q) && (COUNT_W'(i) < count_q);
    end
  end

  assign full = (count_q == COUNT_W'(DEPTH));
  assign empty = (count_q == '0);
  assign hit = |match_q;

  always_comb begin
    shift_en[0] = match_q[0] || (act_q == fqrm_pkg::ACT_POP);
    for (int i = 1; i < DEPTH; i++) begin
      shift_en[i] = shift_en[i-1] || match_q[i];
    end
  end

  always_comb begin
    do_push = 1'b0;
    do_shift = 1'b0;
    count_d = count_q;
    rid = '0;
    rsp_d.status = fqrm_pkg::STS_OK;
    priority if (act_q == fqrm_pkg::ACT_PUSH) begin
      if (full) begin
        rsp_d.status = fqrm_pkg::STS_FULL;
      end else begin
        do_push = 1'b1;
        count_d = count_q + COUNT_W'(1);
      end
    end else if (act_q == fqrm_pkg::ACT_POP || act_q == fqrm_pkg::ACT_REMOVE) begin
      if (empty) begin
        rsp_d.status = fqrm_pkg::STS_EMPTY;
      end else if (act_q == fqrm_pkg::ACT_POP) begin
        do_shift = 1'b1;
        rid = entries_q[0];
        count_d = count_q - COUNT_W'(1);
      end else if (hit) begin
        do_shift = 1'b1;
        rid = pid_q;
        count_d = count_q - COUNT_W'(1);
      end else begin
        rsp_d.status = fqrm_pkg::STS_NOT_FOUND;
      end
    end else begin
      rsp_d.status = fqrm_pkg::STS_OK;
    end
    rsp_d.out_pid = fqrm_pkg::PID_W'(rid);
    rsp_d.count = fqrm_pkg::COUNT_FW'(count_d);
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    always_ff @(posedge clk_i) begin
      if (cmd_i.apply) begin
        if (do_shift && shift_en[i]) begin
          if (i + 1 < DEPTH) begin
            entries_q[i] <= entries_q[(i + 1) % DEPTH];
          end
        end else if (do_push && count_q == COUNT_W'(i)) begin
          entries_q[i] <= pid_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.apply) begin
        count_q <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      rsp_q <= rsp_d;
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o = rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_W'(DEPTH)) else $error("Entry count exceeds the capacity.");

  a_apply_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.apply |-> sts_o.out_free) else $error("Response overwrote a stalled response.");

  a_apply_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.apply |=> out_valid_q) else $error("Applied request produced no response.");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.apply |=> $stable(count_q)) else $error("Count changed without a request.");

endmodule

@@ rtl/fifo_queue_with_remove_by_id_top.sv @@
`timescale 1ns / 1ps

// Bounded run queue of process identifiers with push, pop and remove by key.
// Input channel: in_valid_i, in_stall_o, in_req_i (action and pid). A request
// is taken at a rising edge where in_valid_i is high and in_stall_o is low.
// Output channel: out_valid_o, out_stall_i, out_rsp_o (status, out_pid, count).
// Every request produces exactly one response, in request order.
// Each request passes through three steps: one to capture it, one in which all entry
// cells compare against the key in parallel, and one in which the cells
// collapse toward the head or take the pushed identifier and the response is
// registered. A new request is taken only in the cycle after that, so the block
// does not accept a new request before it is through with the last one.
// When the receiver stalls, the response register holds its contents; a new
// request may still be captured and matched, but it waits in the update step
// until the held response is taken.
// Reset empties the queue and clears the response valid; entry storage is not
// cleared, since no slot is read before it is written.

module fifo_queue_with_remove_by_id_top #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ID_BITS = 22
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  fqrm_pkg::req_t  in_req_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output fqrm_pkg::rsp_t  out_rsp_o
);

  fqrm_pkg::cmd_t cmd;
  fqrm_pkg::sts_t sts;

  fqrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fqrm_datapath #(
    .DEPTH   (DEPTH),
    .ID_BITS (ID_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

@@ dv/fqrm_checker.sv @@
`timescale 1ns / 1ps

module fqrm_checker
  import fqrm_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  req_t        in_req_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  rsp_t        out_rsp_i,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);

  logic [PID_W-1:0] run_queue [DEPTH];
  int unsigned      queued;
  rsp_t             expected_rsp [$];
  int unsigned      fails = 0;

  assign fail_count_o = fails;

  function automatic rsp_t apply_request(input req_t req);
    rsp_t rsp;
    int   hit;
    int   i;
    rsp = '0;
    rsp.status = STS_OK;
    hit = -1;
    case (req.action)
      ACT_PUSH: begin
        if (queued >= DEPTH) begin
          rsp.status = STS_FULL;
        end else begin
          run_queue[queued] = req.pid;
          queued++;
        end
      end
      ACT_POP, ACT_REMOVE: begin
        if (queued == 0) begin
          rsp.status = STS_EMPTY;
        end else begin
          if (req.action == ACT_POP) begin
            hit = 0;
          end else begin
            for (i = 0; i < int'(queued); i++) begin
              if (hit < 0 && run_queue[i] == req.pid) hit = i;
            end
          end
          if (hit < 0) begin
            rsp.status = STS_NOT_FOUND;
          end else begin
            // The entries behind the taken one move up by one, keeping their order.
            rsp.out_pid = run_queue[hit];
            for (i = hit; i < int'(queued) - 1; i++) run_queue[i] = run_queue[i + 1];
            queued--;
          end
        end
      end
      default: begin
      end
    endcase
    rsp.count = COUNT_FW'(queued);
    return rsp;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      queued = 0;
      expected_rsp.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch("response without a request", 32'(out_rsp_i), '0);
        end else begin
          want = expected_rsp.pop_front();
          if (out_rsp_i.status !== want.status)
            report_mismatch("status", 32'(out_rsp_i.status), 32'(want.status));
          if (out_rsp_i.out_pid !== want.out_pid)
            report_mismatch("out_pid", 32'(out_rsp_i.out_pid), 32'(want.out_pid));
          if (out_rsp_i.count !== want.count)
            report_mismatch("count", 32'(out_rsp_i.count), 32'(want.count));
        end
      end
      if (in_valid_i && !in_stall_i) expected_rsp.push_back(apply_request(in_req_i));
      pending_o <= expected_rsp.size();
    end
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import fqrm_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned RANDOM_REQS = 1524;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT = 400000;

  localparam int unsigned MODE_FILL = 0;
  localparam int unsigned MODE_DRAIN = 1;
  localparam int unsigned MODE_MIXED = 2;

  localparam logic [PID_W-1:0] PID_ONES = '1;
  localparam logic [PID_W-1:0] PID_ALT_A = 22'h155555;
  localparam logic [PID_W-1:0] PID_ALT_B = 22'h2AAAAA;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  req_t        in_req = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  rsp_t        out_rsp;
  int unsigned pending;
  int unsigned fail_count;

  int unsigned      src_idle_pct = 11;
  int unsigned      sink_stall_pct = 82;
  int unsigned      cycles = 0;
  logic [PID_W-1:0] pid_pool [8];

  fifo_queue_with_remove_by_id_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp)
  );

  fqrm_checker #(
    .DEPTH(QUEUE_DEPTH)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_rsp_i    (out_rsp),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  task automatic send_req(input logic [1:0] action, input logic [PID_W-1:0] pid);
    req_t req;
    req.action = action;
    req.pid = pid;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [PID_W-1:0] fresh_pid();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 30) return pid_pool[$urandom_range(7)];
    if (roll < 45) return PID_W'($urandom_range(7));
    if (roll < 85) return PID_W'($urandom);
    if (roll < 92) return '0;
    return PID_ONES;
  endfunction

  task automatic send_random(input int unsigned mode);
    int unsigned      roll;
    int unsigned      push_lim;
    int unsigned      pop_lim;
    logic [PID_W-1:0] pid;
    roll = $urandom_range(99);
    case (mode)
      MODE_FILL: begin
        push_lim = 75;
        pop_lim = 85;
      end
      MODE_DRAIN: begin
        push_lim = 15;
        pop_lim = 55;
      end
      default: begin
        push_lim = 40;
        pop_lim = 65;
      end
    endcase
    if (roll < push_lim) begin
      pid = fresh_pid();
      pid_pool[$urandom_range(7)] = pid;
      send_req(ACT_PUSH, pid);
    end else if (roll < pop_lim) begin
      send_req(ACT_POP, PID_W'($urandom));
    end else if (roll < 96) begin
      pid = ($urandom_range(99) < 70) ? pid_pool[$urandom_range(7)] : fresh_pid();
      send_req(ACT_REMOVE, pid);
    end else begin
      send_req(ACT_UNUSED, PID_W'($urandom));
    end
  endtask

  initial begin
    int unsigned      k;
    int unsigned      n;
    int unsigned      phase;
    int unsigned      mode;
    int unsigned      mode_left;
    logic [PID_W-1:0] pid;
    mode = MODE_MIXED;
    mode_left = 0;
    for (k = 0; k < 8; k++) pid_pool[k] = PID_W'($urandom_range(15));
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(ACT_POP, '0);
    send_req(ACT_REMOVE, '0);
    send_req(ACT_PUSH, PID_ONES);
    send_req(ACT_REMOVE, PID_ONES);
    send_req(ACT_POP, '0);
    for (k = 0; k < QUEUE_DEPTH; k++) begin
      case (k)
        0: pid = '0;
        1, 3: pid = PID_ALT_A;
        2: pid = PID_ALT_B;
        QUEUE_DEPTH - 1: pid = PID_ONES;
        default: pid = PID_W'(k);
      endcase
      send_req(ACT_PUSH, pid);
    end
    send_req(ACT_PUSH, PID_W'(7));
    send_req(ACT_UNUSED, PID_ALT_B);
    send_req(ACT_REMOVE, PID_ALT_A);
    send_req(ACT_REMOVE, PID_ONES);
    send_req(ACT_REMOVE, PID_ONES - 1'b1);
    send_req(ACT_POP, PID_ONES);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 11;
          sink_stall_pct = 82;
        end
        1: begin
          src_idle_pct = 82;
          sink_stall_pct = 11;
        end
        default: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
      endcase
      for (n = 0; n < RANDOM_REQS / 3; n++) begin
        if (mode_left == 0) begin
          mode = $urandom_range(MODE_MIXED);
          mode_left = $urandom_range(40, 10);
        end
        mode_left--;
        send_random(mode);
      end
      in_valid <= 1'b0;
      do @(posedge clk); while (pending != 0);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/fqrm_pkg.sv
rtl/fqrm_ctrl.sv
rtl/fqrm_datapath.sv
rtl/fifo_queue_with_remove_by_id_top.sv
dv/fqrm_checker.sv
dv/testbench.sv
